>>> hdl/websocket_frame_deframer_defines.svh
// assertion macros used by the deframer parser
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

`ifndef ASSERT_OFF
`define WSFD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("wsfd assertion failed");
`define WSFD_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("wsfd forbidden condition seen");
`else
`define WSFD_ASSERT(label, clk, rst, prop)
`define WSFD_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

>>> hdl/wsfd_pkg.sv
// types and constants of the websocket frame deframer
package wsfd_pkg;

   localparam int LENGTH_BITS_DEF = 64;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;

   localparam logic [6:0] LEN16_CODE = 7'd126;
   localparam logic [6:0] LEN64_CODE = 7'd127;

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_LEN     = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_CLOSED  = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      EV_DATA  = 2'd0,
      EV_EMPTY = 2'd1,
      EV_CLOSE = 2'd2,
      EV_ABORT = 2'd3
   } evt_type;

   typedef struct packed {
      logic       valid;
      evt_type    evt;
      logic       is_binary;
      logic [7:0] data;
      logic       msg_end;
   } res_type;

endpackage

>>> hdl/wsfd_in_reg.sv
// input register stage holding one received byte
module wsfd_in_reg import wsfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;
   assign valid_in   = (valid_ff && !take) || accept;
   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
      end
   end

endmodule

>>> hdl/wsfd_parser.sv
// frame header parser, unmasking and result decision
`include "websocket_frame_deframer_defines.svh"

module wsfd_parser import wsfd_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output res_type    res
);

   localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

   phase_type              phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic                   masked_ff, masked_in;
   logic [3:0]             opcode_ff, opcode_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [2:0]             hbc_ff, hbc_in;
   logic [1:0]             pos_ff, pos_in;
   logic [7:0]             key_ff [4];
   logic                   key_we;

   logic [LENGTH_BITS-1:0] len_val;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                   len_last;
   logic                   masked_new;
   logic                   hdr_done;
   logic                   len_zero;
   logic                   empty_disp;
   logic                   is_payload;
   logic                   pay_last;
   logic                   dispatch_en;
   logic                   op_data;
   logic                   op_close;
   logic                   op_ping;
   logic                   op_abort;
   logic [7:0]             pay_byte;

   // length assembly for the current header byte
   always_comb begin
      len_val    = rem_ff;
      len_last   = 1'b0;
      masked_new = masked_ff;
      case (phase_ff)
         PH_LEN: begin
            masked_new = rx_byte[7];
            len_last   = !(rx_byte[6:0] inside {LEN16_CODE, LEN64_CODE});
            // extended lengths start from zero
            len_val    = len_last ? LENGTH_BITS'(rx_byte[6:0]) : '0;
         end
         PH_EXT16: begin
            len_val  = LENGTH_BITS'({rem_ff[7:0], rx_byte});
            len_last = (hbc_ff != 3'd0);
         end
         PH_EXT64: begin
            if (rem_ff[LENGTH_BITS-1 -: 8] != 8'h00) begin
               len_val = '1;
            end else begin
               len_val = {rem_ff[LENGTH_BITS-9:0], rx_byte};
            end
            len_last = (hbc_ff == 3'd7);
         end
         default: begin
            len_val = rem_ff;
         end
      endcase
   end

   assign hdr_done    = (len_last && !masked_new) || (phase_ff == PH_KEY && hbc_ff >= 3'd3);
   assign len_zero    = (len_val == '0);
   assign empty_disp  = hdr_done && len_zero && fin_ff;
   assign is_payload  = (phase_ff == PH_PAYLOAD);
   assign rem_dec     = rem_ff - LEN_ONE;
   assign pay_last    = (rem_dec == '0);
   assign dispatch_en = step && (empty_disp || is_payload);

   assign op_data  = (opcode_ff == OP_TEXT) || (opcode_ff == OP_BINARY);
   assign op_close = (opcode_ff == OP_CLOSE);
   assign op_ping  = (opcode_ff == OP_PING);
   assign op_abort = !(op_data || op_close || op_ping);

   assign pay_byte = rx_byte ^ (masked_ff ? key_ff[pos_ff] : 8'h00);

   // next state
   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      masked_in = masked_ff;
      opcode_in = opcode_ff;
      rem_in    = rem_ff;
      hbc_in    = hbc_ff;
      pos_in    = pos_ff;
      key_we    = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_OPCODE: begin
               fin_in = rx_byte[7];
               if (rx_byte[3:0] != OP_CONT) begin
                  opcode_in = rx_byte[3:0];
               end
               hbc_in   = 3'd0;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               masked_in = rx_byte[7];
               rem_in    = len_val;
               hbc_in    = 3'd0;
               if (rx_byte[6:0] == LEN16_CODE) begin
                  phase_in = PH_EXT16;
               end else if (rx_byte[6:0] == LEN64_CODE) begin
                  phase_in = PH_EXT64;
               end else if (masked_new) begin
                  phase_in = PH_KEY;
               end
            end
            PH_EXT16, PH_EXT64: begin
               rem_in = len_val;
               if (len_last) begin
                  hbc_in = 3'd0;
                  if (masked_ff) begin
                     phase_in = PH_KEY;
                  end
               end else begin
                  hbc_in = hbc_ff + 3'd1;
               end
            end
            PH_KEY: begin
               key_we = 1'b1;
               if (hbc_ff < 3'd3) begin
                  hbc_in = hbc_ff + 3'd1;
               end
            end
            PH_PAYLOAD: begin
               rem_in = rem_dec;
               if (masked_ff) begin
                  pos_in = pos_ff + 2'd1;
               end
               if (pay_last) begin
                  phase_in = PH_OPCODE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
         if (hdr_done) begin
            hbc_in   = 3'd0;
            pos_in   = 2'd0;
            phase_in = len_zero ? PH_OPCODE : PH_PAYLOAD;
         end
         if (dispatch_en && (op_close || op_abort)) begin
            phase_in = PH_CLOSED;
         end
      end
   end

   // result
   always_comb begin
      res = '0;
      if (dispatch_en && !op_ping) begin
         res.valid = 1'b1;
         if (op_data) begin
            res.is_binary = (opcode_ff == OP_BINARY);
            if (is_payload) begin
               res.evt     = EV_DATA;
               res.data    = pay_byte;
               res.msg_end = fin_ff && pay_last;
            end else begin
               res.evt     = EV_EMPTY;
               res.msg_end = 1'b1;
            end
         end else if (op_close) begin
            res.evt = EV_CLOSE;
         end else begin
            res.evt = EV_ABORT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         opcode_ff <= OP_CONT;
         rem_ff    <= '0;
         hbc_ff    <= 3'd0;
         pos_ff    <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         opcode_ff <= opcode_in;
         rem_ff    <= rem_in;
         hbc_ff    <= hbc_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff[hbc_ff[1:0]] <= rx_byte;
      end
   end

   // close and abort events both have the upper event bit set
   `WSFD_ASSERT(a_closed_sticky, clock, reset, phase_ff == PH_CLOSED |=> phase_ff == PH_CLOSED)
   `WSFD_ASSERT(a_end_closes, clock, reset, res.valid && res.evt[1] |=> phase_ff == PH_CLOSED)
   `WSFD_ASSERT_NEVER(a_result_without_step, clock, reset, res.valid && !step)
   `WSFD_ASSERT_NEVER(a_payload_zero_len, clock, reset, is_payload && rem_ff == '0)

endmodule

>>> hdl/wsfd_out_reg.sv
// result register driving the output stream
module wsfd_out_reg import wsfd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  res_type    res,
   output logic       out_free,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic [2:0] rsp_tuser,
   output logic       rsp_tlast
);

   logic    valid_ff, valid_in;
   res_type res_ff;

   assign out_free   = !valid_ff || rsp_tready;
   assign valid_in   = (valid_ff && !rsp_tready) || res.valid;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = res_ff.data;
   assign rsp_tuser  = {res_ff.is_binary, res_ff.evt};
   assign rsp_tlast  = res_ff.msg_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         res_ff <= res;
      end
   end

endmodule

>>> hdl/websocket_frame_deframer.sv
// websocket frame deframer top level
// Takes one received WebSocket byte per beat and parses frame headers (FIN, opcode,
// 7/16/64-bit length, masking key), then delivers unmasked text or binary payload
// bytes, an empty-end beat for a zero-length final frame, and close or abort beats,
// after which all input is drained without results until reset. A byte waits in the
// input register and any result it yields in the result register; a new byte is
// taken every cycle as long as the result register is free or being read, so the
// sustained rate is one byte per clock, set by the single-pass per-byte state update.
module websocket_frame_deframer import wsfd_pkg::*; #(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [2:0] rsp_tuser,   // [1:0] event_res, [2] is_binary
   output logic       rsp_tlast    // message_end
);

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       out_free;
   logic       step;
   res_type    res;

   assign step = byte_valid && out_free;

   wsfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   wsfd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (byte_data),
      .res     (res)
   );

   wsfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
